// ----- rtl/assert_macros.svh -----
// Assertion macros used by the valve peak-and-hold driver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property on the rising edge of clk, with arst_n low masking it.
`define VPHD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("valve driver assertion failed");

// Same check with a message of the caller's choosing.
`define VPHD_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`else

`define VPHD_ASSERT(lbl, prop)
`define VPHD_ASSERT_MSG(lbl, prop, msg)

`endif

`endif

// ----- rtl/vphd_pkg.sv -----
// Shared types, codes and constants for the valve peak-and-hold driver.
`timescale 1ns / 1ps

package vphd_pkg;

	// Sizes fixed by the item and register fields.
	localparam int unsigned VALVE_COUNT_DEF = 8;
	localparam int unsigned MASK_W          = 8;
	localparam int unsigned NUM_W           = 4;
	localparam int unsigned MODE_W          = 2;
	localparam int unsigned STATUS_W        = 2;
	localparam int unsigned PERIOD_W        = 10;
	localparam int unsigned DUTY_W          = 8;
	localparam int unsigned CFG_IDX_W       = 2;
	localparam int unsigned CFG_DATA_W      = 10;

	// Reset values of the configuration registers.
	localparam logic [MASK_W-1:0]   PWM_MASK_RST   = 8'd255;
	localparam logic [DUTY_W-1:0]   HOLD_DUTY_RST  = 8'd127;
	localparam logic [PERIOD_W-1:0] AGE_PERIOD_RST = 10'd500;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PWM_MASK   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_DUTY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AGE_PERIOD = 2'd2;

	// Request kinds.
	localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_NUMBER = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OPEN_AGAIN = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_CLOSED     = 2'd3;

	// Per-valve drive states.
	typedef logic [1:0] valve_state_t;
	localparam valve_state_t VS_CLOSED = 2'd0;
	localparam valve_state_t VS_HOLD   = 2'd1;
	localparam valve_state_t VS_OPEN1  = 2'd2;
	localparam valve_state_t VS_OPEN2  = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic execute;
	} dp_cmd_t;

	// One result item.
	typedef struct packed {
		logic                aged;
		logic [MASK_W-1:0]   hold_mask;
		logic [MASK_W-1:0]   full_drive_mask;
		logic [STATUS_W-1:0] status;
	} result_t;

endpackage

// ----- rtl/vphd_ctrl.sv -----
// Controller state machine: request acceptance, execute step and result register flag.
`timescale 1ns / 1ps

module vphd_ctrl import vphd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic exec_go;

	// A captured request executes once the result register is free or emptying.
	assign in_ready      = (state_q == ST_IDLE);
	assign exec_go       = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign cmd.load_item = in_valid && in_ready;
	assign cmd.execute   = exec_go;
	assign out_valid     = out_valid_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (exec_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and result-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/vphd_datapath.sv -----
// Datapath: configuration registers, valve states, tick counter and result register.
`timescale 1ns / 1ps

module vphd_datapath import vphd_pkg::*; #(
	parameter int unsigned VALVE_COUNT = VALVE_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic [MODE_W-1:0]     in_mode,
	input  logic [NUM_W-1:0]      in_num,
	input  dp_cmd_t               cmd,
	output result_t               result
);

	logic [MASK_W-1:0]   pwm_mask_q;
	logic [DUTY_W-1:0]   hold_duty_q;
	logic [PERIOD_W-1:0] age_period_q;
	logic [PERIOD_W-1:0] ms_counter_q;
	logic [MODE_W-1:0]   mode_q;
	logic [NUM_W-1:0]    num_q;
	result_t             result_q;

	valve_state_t        vstate_q [VALVE_COUNT];
	valve_state_t        vstate_d [VALVE_COUNT];
	logic [VALVE_COUNT-1:0] open_again;
	logic [VALVE_COUNT-1:0] close_again;

	logic                num_ok;
	logic                is_tick;
	logic                age_now;
	logic [PERIOD_W:0]   count_inc;
	logic [STATUS_W-1:0] status_d;
	logic [MASK_W-1:0]   full_d;
	logic [MASK_W-1:0]   hold_d;

	// Configuration writes; the hold duty is only stored here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_mask_q   <= PWM_MASK_RST;
			hold_duty_q  <= HOLD_DUTY_RST;
			age_period_q <= AGE_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PWM_MASK:   pwm_mask_q   <= cfg_wdata[MASK_W-1:0];
				REG_HOLD_DUTY:  hold_duty_q  <= cfg_wdata[DUTY_W-1:0];
				REG_AGE_PERIOD: age_period_q <= cfg_wdata[PERIOD_W-1:0];
				default: begin
					hold_duty_q <= hold_duty_q;
				end
			endcase
		end
	end

	// Capture of the accepted request.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q <= in_mode;
			num_q  <= in_num;
		end
	end

	// Decode of the request and the aging decision.
	assign num_ok    = (num_q != '0) && ({1'b0, num_q} <= (NUM_W+1)'(VALVE_COUNT));
	assign is_tick   = (mode_q == MODE_TICK);
	assign count_inc = {1'b0, ms_counter_q} + (PERIOD_W+1)'(1);
	assign age_now   = is_tick && (count_inc > {1'b0, age_period_q});

	// Per-valve next state.
	for (genvar i = 0; i < VALVE_COUNT; i++) begin : g_valve
		logic hit;
		logic pwm_ok;
		assign hit = num_ok && (num_q == NUM_W'(i + 1));
		if (i < MASK_W) begin : g_pwm
			assign pwm_ok = pwm_mask_q[i];
		end else begin : g_no_pwm
			assign pwm_ok = 1'b0;
		end

		always_comb begin
			vstate_d[i]    = vstate_q[i];
			open_again[i]  = 1'b0;
			close_again[i] = 1'b0;
			case (mode_q)
				MODE_OPEN: begin
					if (hit) begin
						if (vstate_q[i] != VS_CLOSED) begin
							open_again[i] = 1'b1;
						end else begin
							vstate_d[i] = VS_OPEN2;
						end
					end
				end
				MODE_CLOSE: begin
					if (hit) begin
						if (vstate_q[i] == VS_CLOSED) begin
							close_again[i] = 1'b1;
						end else begin
							vstate_d[i] = VS_CLOSED;
						end
					end
				end
				MODE_TICK: begin
					if (age_now) begin
						if (vstate_q[i] == VS_OPEN2) begin
							vstate_d[i] = VS_OPEN1;
						end else if ((vstate_q[i] == VS_OPEN1) && pwm_ok) begin
							vstate_d[i] = VS_HOLD;
						end
					end
				end
				default: begin
					vstate_d[i] = vstate_q[i];
				end
			endcase
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vstate_q[i] <= VS_CLOSED;
			end else if (cmd.execute) begin
				vstate_q[i] <= vstate_d[i];
			end
		end
	end

	// Drive masks from the states after the request.
	for (genvar m = 0; m < MASK_W; m++) begin : g_mask
		if (m < VALVE_COUNT) begin : g_used
			assign full_d[m] = (vstate_d[m] == VS_OPEN2) || (vstate_d[m] == VS_OPEN1);
			assign hold_d[m] = (vstate_d[m] == VS_HOLD);
		end else begin : g_unused
			assign full_d[m] = 1'b0;
			assign hold_d[m] = 1'b0;
		end
	end

	// Status of the request.
	always_comb begin
		status_d = STATUS_DONE;
		if ((mode_q == MODE_OPEN) || (mode_q == MODE_CLOSE)) begin
			if (!num_ok) begin
				status_d = STATUS_BAD_NUMBER;
			end else if (|open_again) begin
				status_d = STATUS_OPEN_AGAIN;
			end else if (|close_again) begin
				status_d = STATUS_CLOSED;
			end
		end
	end

	// Millisecond counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_counter_q <= '0;
		end else if (cmd.execute && is_tick) begin
			if (age_now) begin
				ms_counter_q <= '0;
			end else begin
				ms_counter_q <= count_inc[PERIOD_W-1:0];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			result_q.status          <= status_d;
			result_q.full_drive_mask <= full_d;
			result_q.hold_mask       <= hold_d;
			result_q.aged            <= age_now;
		end
	end

	assign result = result_q;

endmodule

// ----- rtl/valve_peak_hold_driver.sv -----
// Top level of the solenoid valve bank driver with peak-and-hold aging.
//
//  Channel   | Direction | Contents
//  s_axis    | in        | tuser: mode; tdata: valve_number
//  m_axis    | out       | tdata: status, full_drive_mask, hold_mask, aged
//  cfg       | in        | write enable, register index, write data
//
// Each request is accepted by the controller in its idle state and then executed
// into the result register in its execute state. One request is in work at a
// time, so a new request is not accepted until the last one has executed.
// A result waiting in the output register does not block acceptance; execution
// of the next request waits until that result is taken.
// Reset is asynchronous and active low; all valves close and the counter clears.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module valve_peak_hold_driver import vphd_pkg::*; #(
	parameter int unsigned VALVE_COUNT = VALVE_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [3:0] valve_number, [7:4] zero
	input  logic [MODE_W-1:0]     s_axis_tuser,  // [1:0] mode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [23:0]           m_axis_tdata,  // [1:0] status, [9:2] full_drive_mask,
	                                             // [17:10] hold_mask, [18] aged, [23:19] zero
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	dp_cmd_t cmd;
	result_t result;

	// Controller.
	vphd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// Datapath.
	vphd_datapath #(
		.VALVE_COUNT (VALVE_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_mode   (s_axis_tuser),
		.in_num    (s_axis_tdata[NUM_W-1:0]),
		.cmd       (cmd),
		.result    (result)
	);

	// Output packing.
	assign m_axis_tdata = {5'd0, result.aged, result.hold_mask, result.full_drive_mask,
		result.status};

	// Only one request is in work: acceptance closes the input for the next cycle.
	`VPHD_ASSERT(a_one_in_work, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
	// An execute step stalled by a waiting result keeps the input closed.
	`VPHD_ASSERT(a_stall_holds, (!s_axis_tready && m_axis_tvalid && !m_axis_tready)
		|=> !s_axis_tready)
	// A valve is never both fully driven and held.
	`VPHD_ASSERT_MSG(a_masks_apart, m_axis_tvalid |-> ((m_axis_tdata[9:2] &
		m_axis_tdata[17:10]) == 8'd0), "valve both fully driven and held")
	// An aging result always comes from a tick, whose status is done.
	`VPHD_ASSERT_MSG(a_aged_done, (m_axis_tvalid && m_axis_tdata[18]) |->
		(m_axis_tdata[1:0] == STATUS_DONE), "aged result with a non-done status")

endmodule
